// File: rtl/ffci_pkg.sv
// ----------------------------------------------------------------------------
// ffci_pkg
// Shared widths, codes and unit interface types for the face flux cell
// integrator.
// ----------------------------------------------------------------------------
package ffci_pkg;

  localparam int CELL_W    = 10;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 48;
  localparam int PROD_W    = ACC_W + DATA_W;
  localparam int MUL_STEPS = DATA_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [1:0] MODE_INTERNAL = 2'd0;
  localparam logic [1:0] MODE_BOUNDARY = 2'd1;
  localparam logic [1:0] MODE_FINISH   = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SAT      = 2'd1;
  localparam logic [1:0] STATUS_ZERO_VOL = 2'd2;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [DATA_W-1:0] VAL_POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VAL_NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  mag_sum;
    logic [DATA_W-1:0] mag_coeff;
    logic [DATA_W-1:0] volume;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic              big;
    logic [DATA_W-1:0] quot;
  } md_rsp_t;

endpackage

// File: rtl/ffci_cell_store.sv
// ----------------------------------------------------------------------------
// ffci_cell_store
// Per-cell accumulator memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffci_cell_store import ffci_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ACC_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [ACC_W-1:0] rdata
);

  logic [ACC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ffci_muldiv.sv
// ----------------------------------------------------------------------------
// ffci_muldiv
// Shared bit-serial unit: magnitude of sum times coefficient, then restoring
// division by volume, both on one 49-bit adder.
// ----------------------------------------------------------------------------
module ffci_muldiv import ffci_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  typedef enum logic [1:0] {P_IDLE, P_MUL, P_DIV} phase_t;

  phase_t              phase;
  logic [STEP_W-1:0]   cnt;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    mcand;
  logic [DATA_W-1:0]   divisor;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   quot;
  logic                big;
  logic                done;

  logic [ACC_W:0]      opa;
  logic [ACC_W:0]      opb;
  logic                cin;
  logic [ACC_W:0]      add_res;
  logic [DATA_W:0]     cur;
  logic                ge;

  assign cur = {rem, prod[PROD_W-1]};

  always_comb begin
    if (phase == P_DIV) begin
      opa = {{(ACC_W-DATA_W){1'b0}}, cur};
      opb = ~{{(ACC_W-DATA_W+1){1'b0}}, divisor};
      cin = 1'b1;
    end else begin
      opa = {1'b0, prod[PROD_W-1:DATA_W]};
      opb = prod[0] ? {1'b0, mcand} : '0;
      cin = 1'b0;
    end
    add_res = opa + opb + {{ACC_W{1'b0}}, cin};
    ge      = ~add_res[ACC_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == P_DIV) && (cnt == STEP_W'(DIV_STEPS - 1));
      unique case (phase)
        P_IDLE: begin
          if (req.start) begin
            prod    <= {{ACC_W{1'b0}}, req.mag_coeff};
            mcand   <= req.mag_sum;
            divisor <= req.volume;
            cnt     <= '0;
            phase   <= P_MUL;
          end
        end
        P_MUL: begin
          prod <= {add_res, prod[DATA_W-1:1]};
          if (cnt == STEP_W'(MUL_STEPS - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            quot  <= '0;
            big   <= 1'b0;
            phase <= P_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        P_DIV: begin
          prod <= {prod[PROD_W-2:0], 1'b0};
          rem  <= ge ? add_res[DATA_W-1:0] : cur[DATA_W-1:0];
          quot <= {quot[DATA_W-2:0], ge};
          big  <= big | quot[DATA_W-1];
          cnt  <= cnt + 1'b1;
          if (cnt == STEP_W'(DIV_STEPS - 1)) begin
            phase <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign rsp = '{done: done, big: big, quot: quot};

endmodule

// File: rtl/face_flux_cell_integrator_top.sv
// ----------------------------------------------------------------------------
// face_flux_cell_integrator_top
// Finite-volume surface integral: scatter-accumulates face fluxes into cell
// sums and emits sum * coeff / volume per finished cell.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   mode 0 adds flux_value to owner_cell and subtracts it from neighbor_cell;
//   mode 1 adds it to owner_cell only; mode 2 finishes owner_cell, clearing
//   its sum and emitting one result; mode 3 is taken and dropped.
//   A result is shown for one cycle with done high; it cannot be held off.
// Sequence: a boundary face reads and updates the owner cell, an internal
//   face then the neighbour cell as well; a finish with zero volume gives its
//   result on the same edge as busy falls, any other finish runs the shared
//   unit for 32 multiply and 80 divide steps, one bit per cycle on one adder.
//   Each face costs one read and one write of the accumulator memory per cell.
// Reset:
//   rst clears the control state, then a sweep writes zero to every cell
//   with busy held high throughout.
// ----------------------------------------------------------------------------
module face_flux_cell_integrator_top import ffci_pkg::*; #(
  parameter int MAX_CELLS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic [CELL_W-1:0]        owner_cell,
  input  logic [CELL_W-1:0]        neighbor_cell,
  input  logic signed [DATA_W-1:0] flux_value,
  input  logic [DATA_W-1:0]        cell_volume,
  input  logic signed [DATA_W-1:0] scale_coeff,
  output logic                     done,
  output logic [CELL_W-1:0]        cell_index,
  output logic signed [DATA_W-1:0] integrated_value,
  output logic [1:0]               status
);

  localparam int AW = $clog2(MAX_CELLS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OWN_RD, S_OWN_ADD, S_NBR_RD, S_NBR_SUB,
    S_FIN_RD, S_FIN_GET, S_FIN_CALC
  } state_t;

  state_t             state;
  logic [AW-1:0]      clr_addr;
  logic [1:0]         cur_mode;
  logic [CELL_W-1:0]  own_cell;
  logic [CELL_W-1:0]  nbr_cell;
  logic               own_ok;
  logic               nbr_ok;
  logic [DATA_W-1:0]  flux;
  logic [DATA_W-1:0]  vol;
  logic [DATA_W-1:0]  coeff;
  logic               neg;

  logic [AW+CELL_W-1:0] own_wide;
  logic [AW+CELL_W-1:0] nbr_wide;
  logic [AW-1:0]        own_addr;
  logic [AW-1:0]        nbr_addr;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ACC_W-1:0]   wdata;
  logic [AW-1:0]      raddr;
  logic [ACC_W-1:0]   rdata;

  logic               acc_sub;
  logic [ACC_W:0]     acc_op;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;

  logic [ACC_W-1:0]   fin_sum;
  logic [ACC_W-1:0]   mag_sum;
  logic [DATA_W-1:0]  mag_coeff;
  md_req_t            md_req;
  md_rsp_t            md_rsp;

  logic               res_sat;
  logic [DATA_W-1:0]  res_val;

  assign own_wide = {{AW{1'b0}}, own_cell};
  assign nbr_wide = {{AW{1'b0}}, nbr_cell};
  assign own_addr = own_wide[AW-1:0];
  assign nbr_addr = nbr_wide[AW-1:0];

  assign busy = (state != S_IDLE);

  // saturating accumulate on the word just read
  always_comb begin
    acc_sub = (state == S_NBR_SUB);
    acc_op  = {{(ACC_W-DATA_W+1){flux[DATA_W-1]}}, flux};
    acc_sum = {rdata[ACC_W-1], rdata} + (acc_sub ? ~acc_op : acc_op)
              + {{ACC_W{1'b0}}, acc_sub};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    fin_sum   = own_ok ? rdata : '0;
    mag_sum   = fin_sum[ACC_W-1] ? (~fin_sum + 1'b1) : fin_sum;
    mag_coeff = coeff[DATA_W-1] ? (~coeff + 1'b1) : coeff;
    md_req    = '{start: (state == S_FIN_GET) && (vol != '0),
                  mag_sum: mag_sum, mag_coeff: mag_coeff, volume: vol};
  end

  always_comb begin
    if (!neg) begin
      res_sat = md_rsp.big | md_rsp.quot[DATA_W-1];
      res_val = res_sat ? VAL_POS_MAX : md_rsp.quot;
    end else begin
      res_sat = md_rsp.big | (md_rsp.quot[DATA_W-1] & (|md_rsp.quot[DATA_W-2:0]));
      res_val = res_sat ? VAL_NEG_MAX : (~md_rsp.quot + 1'b1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = own_addr;
    wdata = acc_sat;
    raddr = own_addr;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      S_OWN_ADD: we = own_ok;
      S_NBR_RD:  raddr = nbr_addr;
      S_NBR_SUB: begin
        we    = nbr_ok;
        waddr = nbr_addr;
      end
      S_FIN_GET: begin
        we    = own_ok;
        wdata = '0;
      end
      default: ;
    endcase
  end

  ffci_cell_store #(
    .DEPTH (MAX_CELLS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ffci_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= ((state == S_FIN_GET) && (vol == '0)) ||
              ((state == S_FIN_CALC) && md_rsp.done);
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur_mode <= mode;
            own_cell <= owner_cell;
            nbr_cell <= neighbor_cell;
            own_ok   <= (32'(owner_cell) < MAX_CELLS);
            nbr_ok   <= (32'(neighbor_cell) < MAX_CELLS);
            flux     <= flux_value;
            vol      <= cell_volume;
            coeff    <= scale_coeff;
            unique case (mode) inside
              MODE_INTERNAL, MODE_BOUNDARY: state <= S_OWN_RD;
              MODE_FINISH:                  state <= S_FIN_RD;
              default:                      state <= S_IDLE;
            endcase
          end
        end
        S_OWN_RD:  state <= S_OWN_ADD;
        S_OWN_ADD: state <= (cur_mode == MODE_INTERNAL) ? S_NBR_RD : S_IDLE;
        S_NBR_RD:  state <= S_NBR_SUB;
        S_NBR_SUB: state <= S_IDLE;
        S_FIN_RD:  state <= S_FIN_GET;
        S_FIN_GET: begin
          neg <= fin_sum[ACC_W-1] ^ coeff[DATA_W-1];
          if (vol == '0) begin
            cell_index       <= own_cell;
            integrated_value <= '0;
            status           <= STATUS_ZERO_VOL;
            state            <= S_IDLE;
          end else begin
            state <= S_FIN_CALC;
          end
        end
        S_FIN_CALC: begin
          if (md_rsp.done) begin
            cell_index       <= own_cell;
            integrated_value <= res_val;
            status           <= res_sat ? STATUS_SAT : STATUS_OK;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_FIN_GET || $past(state) == S_FIN_CALC))
    else $error("result strobe outside a finish transaction");

  a_zero_vol_value: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_ZERO_VOL) |-> (integrated_value == '0))
    else $error("zero-volume result carries a non-zero value");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("transaction possible before clearing sweep");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("accumulator write while idle");

endmodule

// File: tb/sv/tb_face_flux_cell_integrator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_face_flux_cell_integrator_top
// Self-checking bench for the face flux cell integrator. A short table of
// directed transactions covers the field extremes, every mode, saturation of
// the result, zero volume, owner equal to neighbour and ignored mode 3.
// A short run of internal faces builds large opposite sums on two cells.
// Random transactions follow, weighted towards a few busy cells. Each finish result is
// compared field by field with a bit-accurate predictor of the cell sums and the scaled
// quotient, or with a typed row's own expectation. Idle bursts fall between transactions.
// ----------------------------------------------------------------------------
module tb_face_flux_cell_integrator_top import ffci_pkg::*; ();

  localparam int          N_CELLS      = 1024;
  localparam int          RAND_ITEMS   = 1830;
  localparam int          CALM_TAIL    = 300;
  localparam int          SOAK_FACES   = 40;
  localparam int          STALL_LIMIT  = 6000;
  localparam int          TAIL_CYCLES  = 130;
  localparam logic [1:0]  MODE_IGNORED = 2'd3;

  localparam logic signed [ACC_W:0] SUM_HI = $signed({2'b00, {(ACC_W-1){1'b1}}});
  localparam logic signed [ACC_W:0] SUM_LO = $signed({2'b11, {(ACC_W-1){1'b0}}});

  typedef struct packed {
    logic [1:0]        mode;
    logic [CELL_W-1:0] own;
    logic [CELL_W-1:0] nbr;
    logic [DATA_W-1:0] flux;
    logic [DATA_W-1:0] vol;
    logic [DATA_W-1:0] coeff;
    logic              typed;
    logic [DATA_W-1:0] exp_value;
    logic [1:0]        exp_status;
  } stim_entry_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_no;
    logic [DATA_W-1:0] value;
    logic [1:0]        status;
  } cell_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        mode;
  logic [CELL_W-1:0] owner_cell;
  logic [CELL_W-1:0] neighbor_cell;
  logic [DATA_W-1:0] flux_value;
  logic [DATA_W-1:0] cell_volume;
  logic [DATA_W-1:0] scale_coeff;
  logic              done;
  logic [CELL_W-1:0] cell_index;
  logic [DATA_W-1:0] integrated_value;
  logic [1:0]        status;

  logic [ACC_W-1:0]  cell_acc [0:N_CELLS-1];
  cell_result_t      result_q [$];
  cell_result_t      got_exp;
  stim_entry_t       dir_rows [$];

  logic              took;
  logic              row_typed;
  logic [DATA_W-1:0] row_exp_value;
  logic [1:0]        row_exp_status;

  int errors;
  int n_taken;
  int n_checked;
  int n_sat;
  int n_zero_vol;
  int n_ignored;

  face_flux_cell_integrator_top #(
    .MAX_CELLS(N_CELLS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .owner_cell       (owner_cell),
    .neighbor_cell    (neighbor_cell),
    .flux_value       (flux_value),
    .cell_volume      (cell_volume),
    .scale_coeff      (scale_coeff),
    .done             (done),
    .cell_index       (cell_index),
    .integrated_value (integrated_value),
    .status           (status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [ACC_W-1:0] acc_add_sat(logic [ACC_W-1:0] acc,
                                                   logic [DATA_W-1:0] flux, logic negate);
    logic signed [ACC_W:0] a;
    logic signed [ACC_W:0] f;
    logic signed [ACC_W:0] t;
    a = $signed({acc[ACC_W-1], acc});
    f = $signed({{(ACC_W-DATA_W+1){flux[DATA_W-1]}}, flux});
    t = negate ? a - f : a + f;
    if (t > SUM_HI) begin
      acc_add_sat = ACC_MAX;
    end else if (t < SUM_LO) begin
      acc_add_sat = ACC_MIN;
    end else begin
      acc_add_sat = t[ACC_W-1:0];
    end
  endfunction

  function automatic cell_result_t scale_cell_sum(logic [CELL_W-1:0] cell_no,
                                                  logic [ACC_W-1:0] sum,
                                                  logic [DATA_W-1:0] vol,
                                                  logic [DATA_W-1:0] coeff);
    cell_result_t      r;
    logic [ACC_W-1:0]  ms;
    logic [DATA_W-1:0] mc;
    logic [PROD_W-1:0] q;
    logic              neg;
    r.cell_no = cell_no;
    r.status  = STATUS_OK;
    if (vol == '0) begin
      r.value  = '0;
      r.status = STATUS_ZERO_VOL;
    end else begin
      ms  = sum[ACC_W-1] ? -sum : sum;
      mc  = coeff[DATA_W-1] ? -coeff : coeff;
      neg = sum[ACC_W-1] ^ coeff[DATA_W-1];
      q   = ({{DATA_W{1'b0}}, ms} * {{ACC_W{1'b0}}, mc}) / {{ACC_W{1'b0}}, vol};
      if (!neg) begin
        if (q > {{ACC_W{1'b0}}, VAL_POS_MAX}) begin
          r.value  = VAL_POS_MAX;
          r.status = STATUS_SAT;
        end else begin
          r.value = q[DATA_W-1:0];
        end
      end else begin
        if (q > {{ACC_W{1'b0}}, VAL_NEG_MAX}) begin
          r.value  = VAL_NEG_MAX;
          r.status = STATUS_SAT;
        end else begin
          r.value = -q[DATA_W-1:0];
        end
      end
    end
    scale_cell_sum = r;
  endfunction

  // Advance the predicted cell sums by one transaction; queue a finish result.
  task automatic integrate_transaction();
    cell_result_t r;
    case (mode)
      MODE_INTERNAL: begin
        cell_acc[owner_cell]    = acc_add_sat(cell_acc[owner_cell], flux_value, 1'b0);
        cell_acc[neighbor_cell] = acc_add_sat(cell_acc[neighbor_cell], flux_value, 1'b1);
      end
      MODE_BOUNDARY: begin
        cell_acc[owner_cell] = acc_add_sat(cell_acc[owner_cell], flux_value, 1'b0);
      end
      MODE_FINISH: begin
        r = scale_cell_sum(owner_cell, cell_acc[owner_cell], cell_volume, scale_coeff);
        cell_acc[owner_cell] = '0;
        if (row_typed) begin
          r.value  = row_exp_value;
          r.status = row_exp_status;
        end
        result_q.push_back(r);
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  always @(posedge clk) begin
    took <= !rst && start && !busy;
    if (!rst) begin
      if (start && !busy) begin
        n_taken++;
        integrate_transaction();
      end
      if (done) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result: cell %0d value %h status %0d",
                   $time, cell_index, integrated_value, status);
          errors++;
        end else begin
          got_exp = result_q.pop_front();
          n_checked++;
          if (got_exp.status == STATUS_SAT) n_sat++;
          if (got_exp.status == STATUS_ZERO_VOL) n_zero_vol++;
          if (cell_index !== got_exp.cell_no) begin
            $display("%0t: cell_index mismatch: expected %0d actual %0d",
                     $time, got_exp.cell_no, cell_index);
            errors++;
          end
          if (integrated_value !== got_exp.value) begin
            $display("%0t: integrated_value mismatch (cell %0d): expected %h actual %h",
                     $time, got_exp.cell_no, got_exp.value, integrated_value);
            errors++;
          end
          if (status !== got_exp.status) begin
            $display("%0t: status mismatch (cell %0d): expected %0d actual %0d",
                     $time, got_exp.cell_no, got_exp.status, status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (start && !busy) stall = 0;
      else stall++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic stim_entry_t entry(logic [1:0] m, int own,
                                        int nbr, logic [DATA_W-1:0] flux,
                                        logic [DATA_W-1:0] vol, logic [DATA_W-1:0] coeff,
                                        logic typed, logic [DATA_W-1:0] ev, logic [1:0] es);
    stim_entry_t e;
    e.mode       = m;
    e.own        = CELL_W'(own);
    e.nbr        = CELL_W'(nbr);
    e.flux       = flux;
    e.vol        = vol;
    e.coeff      = coeff;
    e.typed      = typed;
    e.exp_value  = ev;
    e.exp_status = es;
    entry = e;
  endfunction

  function automatic logic [CELL_W-1:0] pick_cell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) pick_cell = CELL_W'($urandom_range(0, 15));
    else if (r < 80) pick_cell = ($urandom_range(0, 1) == 0) ? '0 : '1;
    else pick_cell = CELL_W'($urandom);
  endfunction

  function automatic stim_entry_t random_entry();
    stim_entry_t e;
    int r;
    e = entry(MODE_IGNORED, pick_cell(), pick_cell(), $urandom, $urandom, $urandom,
              1'b0, '0, STATUS_OK);
    r = $urandom_range(0, 99);
    if (r < 45) e.mode = MODE_INTERNAL;
    else if (r < 75) e.mode = MODE_BOUNDARY;
    else if (r < 95) e.mode = MODE_FINISH;
    else e.mode = MODE_IGNORED;
    r = $urandom_range(0, 99);
    if (r >= 90) begin
      case ($urandom_range(0, 3))
        0: e.flux = 32'h7FFF_FFFF;
        1: e.flux = 32'h8000_0000;
        2: e.flux = '0;
        default: e.flux = '1;
      endcase
    end else if (r >= 40) begin
      e.flux = DATA_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
    end
    r = $urandom_range(0, 99);
    if (r < 10) e.vol = '0;
    else if (r < 30) e.vol = $urandom;
    else if (r < 60) e.vol = DATA_W'($urandom_range(1, 32'h400));
    else e.vol = DATA_W'($urandom_range(32'h4000, 32'h4_0000));
    if ($urandom_range(0, 99) >= 40) begin
      e.coeff = DATA_W'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
    end
    random_entry = e;
  endfunction

  task automatic drive_item(input stim_entry_t e);
    start          <= 1'b1;
    mode           <= e.mode;
    owner_cell     <= e.own;
    neighbor_cell  <= e.nbr;
    flux_value     <= e.flux;
    cell_volume    <= e.vol;
    scale_coeff    <= e.coeff;
    row_typed      = e.typed;
    row_exp_value  = e.exp_value;
    row_exp_status = e.exp_status;
    @(negedge clk);
    while (!took) @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (result_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic calm;
    calm           = 1'b0;
    errors         = 0;
    n_taken        = 0;
    n_checked      = 0;
    n_sat          = 0;
    n_zero_vol     = 0;
    n_ignored      = 0;
    row_typed      = 1'b0;
    row_exp_value  = '0;
    row_exp_status = STATUS_OK;
    took           = 1'b0;
    rst            = 1'b1;
    start          = 1'b0;
    mode           = MODE_INTERNAL;
    owner_cell     = '0;
    neighbor_cell  = '0;
    flux_value     = '0;
    cell_volume    = '0;
    scale_coeff    = '0;
    for (int c = 0; c < N_CELLS; c++) cell_acc[c] = '0;

    dir_rows.push_back(entry(MODE_FINISH, 0, 0, 0, 32'h1_0000, 32'h1_0000,
                             1'b1, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 1023, 1023, '1, 0, 32'h7FFF_FFFF,
                             1'b1, '0, STATUS_ZERO_VOL));
    dir_rows.push_back(entry(MODE_BOUNDARY, 5, 0, 32'h7FFF_FFFF, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_BOUNDARY, 5, 0, 32'h7FFF_FFFF, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 5, 0, 0, 32'h1_0000, 32'h1_0000,
                             1'b1, VAL_POS_MAX, STATUS_SAT));
    dir_rows.push_back(entry(MODE_INTERNAL, 7, 8, 32'h8000_0000, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 7, 0, 0, '1, 32'h7FFF_FFFF, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 8, 0, 0, 1, 32'h8000_0000,
                             1'b1, VAL_NEG_MAX, STATUS_SAT));
    dir_rows.push_back(entry(MODE_INTERNAL, 9, 9, 32'h1234_5678, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 9, 0, 0, 32'h1_0000, 32'h7FFF_FFFF,
                             1'b1, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 5, 0, 0, 32'h1_0000, 32'h8000_0000,
                             1'b1, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_IGNORED, 3, 3, 32'h7FFF_FFFF, '1, '1, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 3, 0, 0, 32'h1_0000, 32'h1_0000,
                             1'b1, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_BOUNDARY, 10, 0, 32'h1_0000, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 10, 0, 0, 32'h2_0000, 32'h3_0000,
                             1'b1, 32'h1_8000, STATUS_OK));
    // Truncate towards zero on a negative quotient.
    dir_rows.push_back(entry(MODE_BOUNDARY, 11, 0, 32'hFFFF_FFFD, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 11, 0, 0, 2, 1, 1'b1, 32'hFFFF_FFFF, STATUS_OK));
    dir_rows.push_back(entry(MODE_BOUNDARY, 12, 0, 32'h8000_0000, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 12, 0, 0, 1, 1, 1'b1, VAL_NEG_MAX, STATUS_OK));
    dir_rows.push_back(entry(MODE_BOUNDARY, 13, 0, 32'h7FFF_FFFF, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 13, 0, 0, 1, 1, 1'b1, VAL_POS_MAX, STATUS_OK));
    dir_rows.push_back(entry(MODE_BOUNDARY, 14, 0, 32'h1234, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 14, 0, 0, 0, 1, 1'b1, '0, STATUS_ZERO_VOL));
    dir_rows.push_back(entry(MODE_FINISH, 14, 0, 0, 1, 1, 1'b1, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_INTERNAL, 0, 1023, 32'h5_0000, 0, 0, 1'b0, '0, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 1023, 0, 0, 32'h1_0000, 32'h1_0000,
                             1'b1, 32'hFFFB_0000, STATUS_OK));
    dir_rows.push_back(entry(MODE_FINISH, 0, 0, 0, '1, 32'h7FFF_FFFF, 1'b0, '0, STATUS_OK));

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      drive_item(dir_rows[k]);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 18));
    end
    drain_results();

    // Build a large sum on one cell and its opposite on the neighbour, then pull each back.
    for (int k = 0; k < SOAK_FACES; k++) begin
      drive_item(entry(MODE_INTERNAL, 20, 21, 32'h7FFF_FFFF, $urandom, $urandom,
                       1'b0, '0, STATUS_OK));
    end
    drive_item(entry(MODE_BOUNDARY, 20, 0, 32'hFFFF_0000, 0, 0, 1'b0, '0, STATUS_OK));
    drive_item(entry(MODE_BOUNDARY, 21, 0, 32'h0001_0000, 0, 0, 1'b0, '0, STATUS_OK));
    drive_item(entry(MODE_FINISH, 20, 0, 0, '1, 1, 1'b0, '0, STATUS_OK));
    drive_item(entry(MODE_FINISH, 21, 0, 0, 32'h1_0000, 1, 1'b0, '0, STATUS_OK));
    drain_results();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i % 400 == 399) drain_results();
      drive_item(random_entry());
      if (i < RAND_ITEMS - CALM_TAIL && !calm && $urandom_range(0, 2) == 0) begin
        idle_for($urandom_range(1, 18));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Summary: %0d transactions taken (%0d ignored mode 3), %0d cell results checked",
             n_taken, n_ignored, n_checked);
    $display("Summary: %0d saturated, %0d zero volume, run of %0d faces on one cell pair",
             n_sat, n_zero_vol, SOAK_FACES);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
